[rtl/core/asu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Arithmetic shift unit package
// Beat payload types, operand size codes, flag positions and decode controls.
// ----------------------------------------------------------------------------
package asu_pkg;

   // Flag bit positions in the five-bit condition code field
   localparam int FLAG_X = 4;
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_V = 1;
   localparam int FLAG_C = 0;

   // Opcode field positions
   localparam int OPC_CNT_MSB  = 11;
   localparam int OPC_CNT_LSB  = 9;
   localparam int OPC_LEFT     = 8;
   localparam int OPC_SIZE_MSB = 7;
   localparam int OPC_SIZE_LSB = 6;
   localparam int OPC_REGCNT   = 5;

   localparam int CNT_W   = 6;
   localparam int DATA_W  = 32;
   localparam int WIDTH_W = 6;

   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_LONG = 2'd2,
      SIZE_MEM  = 2'd3
   } size_type;

   typedef struct packed {
      logic [15:0] opcode;
      logic [31:0] dest_value;
      logic [5:0]  count_value;
      logic [15:0] mem_word;
      logic [4:0]  flags_in;
   } req_type;

   typedef struct packed {
      logic [31:0] reg_result;
      logic [15:0] mem_result;
      logic        writes_reg;
      logic        writes_mem;
      logic [4:0]  flags_out;
   } rsp_type;

   // Decoded controls; the operand is left-aligned to bit 31
   typedef struct packed {
      size_type             size;
      logic                 left;
      logic                 zero_cnt;
      logic [CNT_W-1:0]     cnt;
      logic [WIDTH_W-1:0]   width;
      logic [DATA_W-1:0]    op_hi;
      logic [DATA_W-1:0]    mask_hi;
      logic                 xin;
   } ctl_type;

endpackage
`default_nettype wire

[rtl/core/asu_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Arithmetic shift unit decoder
// Picks size, direction and count from the opcode and aligns the operand.
// ----------------------------------------------------------------------------
module asu_decode (
   input  asu_pkg::req_type req,
   output asu_pkg::ctl_type ctl
);
   import asu_pkg::*;

   logic [2:0]       imm_cnt;
   logic [CNT_W-1:0] reg_cnt;

   always_comb begin
      imm_cnt = req.opcode[OPC_CNT_MSB:OPC_CNT_LSB];
      // immediate zero encodes eight
      if (req.opcode[OPC_REGCNT]) begin
         reg_cnt = req.count_value;
      end else if (imm_cnt == 3'd0) begin
         reg_cnt = CNT_W'(8);
      end else begin
         reg_cnt = {3'b000, imm_cnt};
      end

      ctl.size = size_type'(req.opcode[OPC_SIZE_MSB:OPC_SIZE_LSB]);
      ctl.left = req.opcode[OPC_LEFT];
      ctl.xin  = req.flags_in[FLAG_X];
      ctl.cnt  = reg_cnt;

      unique case (ctl.size)
         SIZE_BYTE: begin
            ctl.width   = WIDTH_W'(8);
            ctl.op_hi   = {req.dest_value[7:0], 24'h0};
            ctl.mask_hi = {8'hFF, 24'h0};
         end
         SIZE_WORD: begin
            ctl.width   = WIDTH_W'(16);
            ctl.op_hi   = {req.dest_value[15:0], 16'h0};
            ctl.mask_hi = {16'hFFFF, 16'h0};
         end
         SIZE_LONG: begin
            ctl.width   = WIDTH_W'(32);
            ctl.op_hi   = req.dest_value;
            ctl.mask_hi = 32'hFFFF_FFFF;
         end
         SIZE_MEM: begin
            // memory form always shifts one place
            ctl.width   = WIDTH_W'(16);
            ctl.op_hi   = {req.mem_word, 16'h0};
            ctl.mask_hi = {16'hFFFF, 16'h0};
            ctl.cnt     = CNT_W'(1);
         end
         default: begin
            ctl.width   = WIDTH_W'(32);
            ctl.op_hi   = req.dest_value;
            ctl.mask_hi = 32'hFFFF_FFFF;
         end
      endcase

      ctl.zero_cnt = (ctl.cnt == '0);
   end

endmodule
`default_nettype wire

[rtl/core/asu_shift.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Arithmetic shift unit datapath
// Barrel shift of the aligned operand with X N Z V C generation.
// ----------------------------------------------------------------------------
module asu_shift (
   input  asu_pkg::ctl_type ctl,
   output logic [31:0]      res_hi,
   output logic [4:0]       flags
);
   import asu_pkg::*;

   logic [63:0]       lsh;
   logic [63:0]       rsh;
   logic [DATA_W-1:0] m_hi;
   logic [DATA_W-1:0] t_hi;
   logic [6:0]        cnt_p1;
   logic              big;
   logic              c;
   logic              v;
   logic              x;

   always_comb begin
      lsh    = {32'h0, ctl.op_hi} << ctl.cnt;
      rsh    = 64'($signed({ctl.op_hi, 32'h0}) >>> ctl.cnt);
      big    = (ctl.cnt >= ctl.width);
      cnt_p1 = {1'b0, ctl.cnt} + 7'd1;
      // top cnt+1 bits: sign changes if they are not all equal
      m_hi   = ~(32'hFFFF_FFFF >> cnt_p1);
      t_hi   = ctl.op_hi & m_hi;

      if (ctl.zero_cnt) begin
         res_hi = ctl.op_hi;
         c      = 1'b0;
         v      = 1'b0;
         x      = ctl.xin;
      end else if (ctl.left) begin
         res_hi = lsh[31:0] & ctl.mask_hi;
         c      = lsh[32];
         v      = big ? (ctl.op_hi != '0) : ((t_hi != '0) && (t_hi != m_hi));
         x      = c;
      end else begin
         res_hi = rsh[63:32] & ctl.mask_hi;
         // last bit out sits just below the operand field
         unique case (ctl.size)
            SIZE_BYTE: c = rsh[55];
            SIZE_WORD: c = rsh[47];
            SIZE_LONG: c = rsh[31];
            SIZE_MEM:  c = rsh[47];
            default:   c = rsh[31];
         endcase
         v = 1'b0;
         x = c;
      end

      flags         = '0;
      flags[FLAG_X] = x;
      flags[FLAG_N] = res_hi[31];
      flags[FLAG_Z] = (res_hi == '0);
      flags[FLAG_V] = v;
      flags[FLAG_C] = c;
   end

endmodule
`default_nettype wire

[rtl/core/arithmetic_shift_unit.sv]
`default_nettype none
// Pipeline: the request beat is captured in the input register, then its result
// in the result register, which holds it while rsp_stall is high.
// Throughput: one beat per cycle while rsp_stall does not hold the response;
// the single pass through decode and barrel shifter sets the rate. Reset clears
// both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
// Arithmetic shift unit
// Executes one ASL/ASR instruction word per beat on a register or memory word.
// ----------------------------------------------------------------------------
module arithmetic_shift_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  asu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output asu_pkg::rsp_type rsp_data
);
   import asu_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    out_ready;
   ctl_type ctl;
   logic [31:0] res_hi;
   logic [4:0]  flags;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_ready;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = out_ready ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (in_valid_ff && out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   asu_decode u_decode (
      .req (in_data_ff),
      .ctl (ctl)
   );

   asu_shift u_shift (
      .ctl    (ctl),
      .res_hi (res_hi),
      .flags  (flags)
   );

   // put the shifted field back under the untouched upper bits
   always_comb begin
      rsp_data_in.flags_out  = flags;
      rsp_data_in.writes_reg = 1'b1;
      rsp_data_in.writes_mem = 1'b0;
      rsp_data_in.mem_result = '0;
      unique case (ctl.size)
         SIZE_BYTE: rsp_data_in.reg_result = {in_data_ff.dest_value[31:8], res_hi[31:24]};
         SIZE_WORD: rsp_data_in.reg_result = {in_data_ff.dest_value[31:16], res_hi[31:16]};
         SIZE_LONG: rsp_data_in.reg_result = res_hi;
         SIZE_MEM: begin
            rsp_data_in.reg_result = in_data_ff.dest_value;
            rsp_data_in.mem_result = res_hi[31:16];
            rsp_data_in.writes_reg = 1'b0;
            rsp_data_in.writes_mem = 1'b1;
         end
         default: rsp_data_in.reg_result = res_hi;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.writes_reg != rsp_data.writes_mem))
      else $error("response must write exactly one target");

   a_mem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.writes_reg |-> (rsp_data.mem_result == 16'h0))
      else $error("register form left memory result nonzero");

   a_mem_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.writes_mem |->
         (rsp_data.flags_out[FLAG_N] == rsp_data.mem_result[15]) &&
         (rsp_data.flags_out[FLAG_Z] == (rsp_data.mem_result == 16'h0)))
      else $error("memory form N/Z disagree with result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && in_valid_ff)
      else $error("request stalled without a blocked response");
`endif

endmodule
`default_nettype wire
